### hw/rtl/ssimu_pkg.sv
// shared types, constants and saturating helpers for the spectral mode update
// no dependencies
package ssimu_pkg;

	localparam int Q_FRAC    = 32;
	localparam int DIV_STEPS = 64 + Q_FRAC;

	localparam logic signed [63:0] Q_ONE = 64'sh0000_0001_0000_0000;
	localparam logic signed [63:0] Q_MAX = 64'sh7fff_ffff_ffff_ffff;
	localparam logic signed [63:0] Q_MIN = 64'sh8000_0000_0000_0000;
	localparam logic [63:0]        TOP_BIT = 64'h8000_0000_0000_0000;

	typedef enum logic [2:0] {
		REG_STEP    = 3'd0,
		REG_IFACE   = 3'd1,
		REG_LRANGE  = 3'd2,
		REG_STAB    = 3'd3,
		REG_MEAN    = 3'd4,
		REG_DEALIAS = 3'd5
	} cfg_reg_e;

	typedef struct packed {
		logic signed [63:0] lin_re;
		logic signed [63:0] lin_im;
		logic signed [63:0] cube_re;
		logic signed [63:0] cube_im;
		logic [62:0]        sym_k2;
		logic [62:0]        sym_k4;
		logic               keep_mode;
		logic               zero_mode;
	} item_t;

	typedef struct packed {
		logic signed [63:0] new_re;
		logic signed [63:0] new_im;
		logic               overflow;
	} result_t;

	typedef struct packed {
		logic [62:0]        step_size;
		logic [62:0]        interface_coeff;
		logic [62:0]        long_range_coeff;
		logic [62:0]        stabilization;
		logic signed [63:0] scaled_mean;
		logic               dealias_on;
	} cfg_t;

	typedef struct packed {
		logic               ovf;
		logic signed [63:0] val;
	} sat_t;

	// saturating signed add
	function automatic sat_t sat_add(input logic signed [63:0] a, input logic signed [63:0] b);
		logic [64:0] s;
		sat_t r;
		s = {a[63], a} + {b[63], b};
		r.ovf = s[64] ^ s[63];
		if (r.ovf) r.val = s[64] ? Q_MIN : Q_MAX;
		else r.val = s[63:0];
		return r;
	endfunction

	// saturating signed subtract
	function automatic sat_t sat_sub(input logic signed [63:0] a, input logic signed [63:0] b);
		logic [64:0] s;
		sat_t r;
		s = {a[63], a} - {b[63], b};
		r.ovf = s[64] ^ s[63];
		if (r.ovf) r.val = s[64] ? Q_MIN : Q_MAX;
		else r.val = s[63:0];
		return r;
	endfunction

	// apply sign to a magnitude and saturate
	function automatic sat_t pack_mag(input logic neg, input logic [63:0] m, input logic big);
		sat_t r;
		r.ovf = 1'b0;
		if (neg) begin
			if (big || m > TOP_BIT) begin
				r.ovf = 1'b1;
				r.val = Q_MIN;
			end else begin
				r.val = ~m + 64'd1;
			end
		end else begin
			if (big || m[63]) begin
				r.ovf = 1'b1;
				r.val = Q_MAX;
			end else begin
				r.val = m;
			end
		end
		return r;
	endfunction

endpackage

### hw/rtl/ssimu_front.sv
// front end: accepts mode requests, applies the dealias mask, two-entry queue
// depends on ssimu_pkg
module ssimu_front import ssimu_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  push,
	output logic  full,
	input  item_t item,
	input  logic  dealias_on,
	output item_t head,
	output logic  head_vld,
	input  logic  take
);

	item_t      ent_q [0:1];
	logic       wr_q;
	logic       rd_q;
	logic [1:0] cnt_q;
	item_t      masked;
	logic       do_push;
	logic       do_pop;

	// drop the nonlinear term outside the dealias region
	always_comb begin
		masked = item;
		if (dealias_on && !item.keep_mode) begin
			masked.cube_re = '0;
			masked.cube_im = '0;
		end
	end

	assign full     = (cnt_q == 2'd2);
	assign head_vld = (cnt_q != 2'd0);
	assign head     = ent_q[rd_q];
	assign do_push  = push && !full;
	assign do_pop   = take && head_vld;

	// queue storage
	always_ff @(posedge clk) begin
		if (do_push) ent_q[wr_q] <= masked;
	end

	// queue pointers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= 1'b0;
			rd_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (do_push) wr_q <= ~wr_q;
			if (do_pop) rd_q <= ~rd_q;
			if (do_push && !do_pop) cnt_q <= cnt_q + 2'd1;
			else if (do_pop && !do_push) cnt_q <= cnt_q - 2'd1;
		end
	end

endmodule

### hw/rtl/ssimu_mul.sv
// three-stage saturating Q32.32 multiplier built from 32x32 partial products
// depends on ssimu_pkg
module ssimu_mul import ssimu_pkg::*; (
	input  logic               clk,
	input  logic               en,
	input  logic signed [63:0] a,
	input  logic signed [63:0] b,
	output sat_t               p
);

	logic        neg_s1;
	logic [63:0] ma_s1;
	logic [63:0] mb_s1;
	logic        neg_s2;
	logic [63:0] p00_s2, p01_s2, p10_s2, p11_s2;
	sat_t        p_s3;
	logic [127:0] prod;

	// magnitudes and sign
	always_ff @(posedge clk) begin
		if (en) begin
			neg_s1 <= a[63] ^ b[63];
			ma_s1  <= a[63] ? (~a + 64'd1) : a;
			mb_s1  <= b[63] ? (~b + 64'd1) : b;
		end
	end

	// partial products
	always_ff @(posedge clk) begin
		if (en) begin
			neg_s2 <= neg_s1;
			p00_s2 <= ma_s1[31:0]  * mb_s1[31:0];
			p01_s2 <= ma_s1[31:0]  * mb_s1[63:32];
			p10_s2 <= ma_s1[63:32] * mb_s1[31:0];
			p11_s2 <= ma_s1[63:32] * mb_s1[63:32];
		end
	end

	// sum, truncate to Q32.32 and saturate
	assign prod = {64'd0, p00_s2} + {32'd0, p01_s2, 32'd0} + {32'd0, p10_s2, 32'd0}
		+ {p11_s2, 64'd0};

	always_ff @(posedge clk) begin
		if (en) p_s3 <= pack_mag(neg_s2, prod[95:32], |prod[127:96]);
	end

	assign p = p_s3;

endmodule

### hw/rtl/ssimu_div.sv
// pipelined restoring divider, one quotient bit per stage, both parts side by side
// depends on ssimu_pkg
module ssimu_div import ssimu_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               en,
	input  logic               in_vld,
	input  logic signed [63:0] nre,
	input  logic signed [63:0] nim,
	input  logic signed [63:0] den,
	input  logic               ovf,
	output logic               out_vld,
	output result_t            res
);

	typedef struct packed {
		logic [63:0]           r_re;
		logic [63:0]           r_im;
		logic [DIV_STEPS-1:0]  q_re;
		logic [DIV_STEPS-1:0]  q_im;
		logic [63:0]           mn_re;
		logic [63:0]           mn_im;
		logic                  neg_re;
		logic                  neg_im;
		logic                  nz_re;
		logic                  nz_im;
		logic [62:0]           ud;
		logic                  byp;
		logic                  ovf;
	} dstg_t;

	dstg_t              dv_q [0:DIV_STEPS];
	logic [DIV_STEPS:0] vld_q;
	dstg_t              prep;
	sat_t               pr;
	sat_t               pi;

	function automatic logic [64:0] div_step(input logic [63:0] r, input logic b,
		input logic [62:0] ud);
		logic [63:0] rs;
		logic [64:0] o;
		rs = {r[62:0], b};
		if (rs >= {1'b0, ud}) o = {1'b1, rs - {1'b0, ud}};
		else o = {1'b0, rs};
		return o;
	endfunction

	// magnitudes, divisor check
	always_comb begin
		prep        = '0;
		prep.neg_re = nre[63];
		prep.neg_im = nim[63];
		prep.nz_re  = (nre != '0);
		prep.nz_im  = (nim != '0);
		prep.mn_re  = nre[63] ? (~nre + 64'd1) : nre;
		prep.mn_im  = nim[63] ? (~nim + 64'd1) : nim;
		prep.ud     = den[62:0];
		prep.byp    = den[63] || (den == '0);
		prep.ovf    = ovf || den[63] || (den == '0);
	end

	always_ff @(posedge clk) begin
		if (en) dv_q[0] <= prep;
	end

	// one quotient bit per stage
	for (genvar j = 0; j < DIV_STEPS; j++) begin : g_step
		localparam int BITPOS = DIV_STEPS - 1 - j - Q_FRAC;
		logic        b_re;
		logic        b_im;
		logic [64:0] sr;
		logic [64:0] si;
		dstg_t       nx;

		if (BITPOS >= 0) begin : g_bit
			assign b_re = dv_q[j].mn_re[BITPOS];
			assign b_im = dv_q[j].mn_im[BITPOS];
		end else begin : g_zero
			assign b_re = 1'b0;
			assign b_im = 1'b0;
		end

		assign sr = div_step(dv_q[j].r_re, b_re, dv_q[j].ud);
		assign si = div_step(dv_q[j].r_im, b_im, dv_q[j].ud);

		// next stage contents
		always_comb begin
			nx      = dv_q[j];
			nx.r_re = sr[63:0];
			nx.r_im = si[63:0];
			nx.q_re = {dv_q[j].q_re[DIV_STEPS-2:0], sr[64]};
			nx.q_im = {dv_q[j].q_im[DIV_STEPS-2:0], si[64]};
		end

		always_ff @(posedge clk) begin
			if (en) dv_q[j+1] <= nx;
		end
	end

	// valid bits follow the data
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_q <= '0;
		else if (en) vld_q <= {vld_q[DIV_STEPS-1:0], in_vld};
	end

	// sign, saturation, or sign-only result when the divisor is not positive
	assign pr = pack_mag(dv_q[DIV_STEPS].neg_re, dv_q[DIV_STEPS].q_re[63:0],
		|dv_q[DIV_STEPS].q_re[DIV_STEPS-1:64]);
	assign pi = pack_mag(dv_q[DIV_STEPS].neg_im, dv_q[DIV_STEPS].q_im[63:0],
		|dv_q[DIV_STEPS].q_im[DIV_STEPS-1:64]);

	always_comb begin
		if (dv_q[DIV_STEPS].byp) begin
			res.new_re = dv_q[DIV_STEPS].neg_re ? Q_MIN
				: (dv_q[DIV_STEPS].nz_re ? Q_MAX : '0);
			res.new_im = dv_q[DIV_STEPS].neg_im ? Q_MIN
				: (dv_q[DIV_STEPS].nz_im ? Q_MAX : '0);
			res.overflow = 1'b1;
		end else begin
			res.new_re   = pr.val;
			res.new_im   = pi.val;
			res.overflow = dv_q[DIV_STEPS].ovf | pr.ovf | pi.ovf;
		end
	end

	assign out_vld = vld_q[DIV_STEPS];

endmodule

### hw/rtl/ssimu_back.sv
// back end: numerator/denominator pipeline, divider and output register
// depends on ssimu_pkg, ssimu_mul, ssimu_div
module ssimu_back import ssimu_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  cfg_t    cfg,
	input  item_t   head,
	input  logic    head_vld,
	output logic    take,
	output result_t result,
	output logic    empty,
	input  logic    pop
);

	localparam int NSTG = 14;

	typedef struct packed {
		logic signed [63:0] lin_re, lin_im, cube_re, cube_im, k2, k4;
		logic               zero;
		logic signed [63:0] dk2, stab, de, ds, dstab, den, gain;
		logic signed [63:0] pc_re, pc_im, frc, nre, nim;
		logic               ovf;
	} ctx_t;

	ctx_t              ctx_q [0:NSTG-1];
	ctx_t              nxt   [1:NSTG-1];
	ctx_t              ld;
	logic [NSTG-1:0]   cv_q;
	logic              en;
	result_t           out_q;
	logic              out_v_q;
	logic signed [63:0] dt;
	sat_t m_dk2, m_stab, m_de, m_ds;
	sat_t m_dstab, m_dek4, m_pcr, m_pci, m_frc;
	sat_t m_plr, m_pli;
	sat_t s4, s8d, s8g, s9, s10, s12r, s12i, s13;
	logic              dv_vld;
	result_t           dv_res;

	// whole pipeline moves unless a finished result is still waiting
	assign en   = !out_v_q || pop;
	assign take = en && head_vld;
	assign dt   = {1'b0, cfg.step_size};

	// load stage
	always_comb begin
		ld         = '0;
		ld.lin_re  = head.lin_re;
		ld.lin_im  = head.lin_im;
		ld.cube_re = head.cube_re;
		ld.cube_im = head.cube_im;
		ld.k2      = {1'b0, head.sym_k2};
		ld.k4      = {1'b0, head.sym_k4};
		ld.zero    = head.zero_mode;
	end

	// first products: dt*k2, S*k2, dt*eps2, dt*sigma
	ssimu_mul u_dk2  (.clk, .en, .a(dt), .b(ctx_q[0].k2), .p(m_dk2));
	ssimu_mul u_stab (.clk, .en, .a({1'b0, cfg.stabilization}), .b(ctx_q[0].k2), .p(m_stab));
	ssimu_mul u_de   (.clk, .en, .a(dt), .b({1'b0, cfg.interface_coeff}), .p(m_de));
	ssimu_mul u_ds   (.clk, .en, .a(dt), .b({1'b0, cfg.long_range_coeff}), .p(m_ds));

	// second products
	ssimu_mul u_dstab (.clk, .en, .a(dt), .b(ctx_q[4].stab), .p(m_dstab));
	ssimu_mul u_dek4  (.clk, .en, .a(ctx_q[4].de), .b(ctx_q[4].k4), .p(m_dek4));
	ssimu_mul u_pcr   (.clk, .en, .a(ctx_q[4].dk2), .b(ctx_q[4].cube_re), .p(m_pcr));
	ssimu_mul u_pci   (.clk, .en, .a(ctx_q[4].dk2), .b(ctx_q[4].cube_im), .p(m_pci));
	ssimu_mul u_frc   (.clk, .en, .a(ctx_q[4].ds), .b(cfg.scaled_mean), .p(m_frc));

	// gain times field
	ssimu_mul u_plr (.clk, .en, .a(ctx_q[8].gain), .b(ctx_q[8].lin_re), .p(m_plr));
	ssimu_mul u_pli (.clk, .en, .a(ctx_q[8].gain), .b(ctx_q[8].lin_im), .p(m_pli));

	// stage updates
	always_comb begin
		for (int k = 1; k < NSTG; k++) nxt[k] = ctx_q[k-1];
		s4   = sat_sub(Q_ONE, m_dk2.val);
		s8d  = sat_add(ctx_q[7].den, m_dek4.val);
		s8g  = sat_add(Q_ONE, m_dstab.val);
		s9   = sat_add(ctx_q[8].den, ctx_q[8].ds);
		s10  = sat_add(ctx_q[9].den, ctx_q[9].dstab);
		s12r = sat_sub(m_plr.val, ctx_q[11].pc_re);
		s12i = sat_sub(m_pli.val, ctx_q[11].pc_im);
		s13  = sat_add(ctx_q[12].nre, ctx_q[12].frc);

		// den starts as 1 - dt*k2
		nxt[4].dk2  = m_dk2.val;
		nxt[4].stab = m_stab.val;
		nxt[4].de   = m_de.val;
		nxt[4].ds   = m_ds.val;
		nxt[4].den  = s4.val;
		nxt[4].ovf  = ctx_q[3].ovf | m_dk2.ovf | m_stab.ovf | m_de.ovf | m_ds.ovf | s4.ovf;

		// add dt*eps2*k4, form the gain
		nxt[8].dstab = m_dstab.val;
		nxt[8].pc_re = m_pcr.val;
		nxt[8].pc_im = m_pci.val;
		nxt[8].frc   = m_frc.val;
		nxt[8].den   = s8d.val;
		nxt[8].gain  = s8g.val;
		nxt[8].ovf   = ctx_q[7].ovf | m_dstab.ovf | m_dek4.ovf | m_pcr.ovf | m_pci.ovf
			| (ctx_q[7].zero & m_frc.ovf) | s8d.ovf | s8g.ovf;

		// add dt*sigma, then dt*S*k2
		nxt[9].den  = s9.val;
		nxt[9].ovf  = ctx_q[8].ovf | s9.ovf;
		nxt[10].den = s10.val;
		nxt[10].ovf = ctx_q[9].ovf | s10.ovf;

		// numerators
		nxt[12].nre = s12r.val;
		nxt[12].nim = s12i.val;
		nxt[12].ovf = ctx_q[11].ovf | m_plr.ovf | m_pli.ovf | s12r.ovf | s12i.ovf;

		// mean forcing on the constant mode
		if (ctx_q[12].zero) begin
			nxt[13].nre = s13.val;
			nxt[13].ovf = ctx_q[12].ovf | s13.ovf;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ctx_q[0] <= ld;
			for (int k = 1; k < NSTG; k++) ctx_q[k] <= nxt[k];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) cv_q <= '0;
		else if (en) cv_q <= {cv_q[NSTG-2:0], head_vld};
	end

	ssimu_div u_div (
		.clk,
		.arst_n,
		.en,
		.in_vld (cv_q[NSTG-1]),
		.nre    (ctx_q[NSTG-1].nre),
		.nim    (ctx_q[NSTG-1].nim),
		.den    (ctx_q[NSTG-1].den),
		.ovf    (ctx_q[NSTG-1].ovf),
		.out_vld(dv_vld),
		.res    (dv_res)
	);

	// output register
	always_ff @(posedge clk) begin
		if (en) out_q <= dv_res;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) out_v_q <= 1'b0;
		else if (en) out_v_q <= dv_vld;
	end

	assign result = out_q;
	assign empty  = !out_v_q;

endmodule

### hw/rtl/spectral_semi_implicit_mode_update.sv
// Semi-implicit spectral update of one Cahn-Hilliard mode per request, Q32.32 throughout.
// Takes one mode per cycle and returns one result per cycle while pop keeps up; a result
// passes through a two-entry input queue, a 14-stage numerator/denominator pipeline built
// on 32x32 partial-product multipliers, a 96-stage divider behind its input register that
// retires one quotient bit per stage, and the output register.
// The whole pipeline holds while a result waits unpopped; full then rises once both queue entries fill.
// Configuration writes are always ready and must only be made while no request is in flight.
// depends on ssimu_pkg, ssimu_front, ssimu_back
module spectral_semi_implicit_mode_update import ssimu_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	output logic        full,
	input  item_t       item,
	output logic        empty,
	input  logic        pop,
	output result_t     result,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [2:0]  cfg_index,
	input  logic [63:0] cfg_data
);

	cfg_t  cfg_q;
	item_t head;
	logic  head_vld;
	logic  take;

	assign cfg_ready = 1'b1;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (cfg_valid) begin
			case (cfg_reg_e'(cfg_index))
				REG_STEP:    cfg_q.step_size        <= cfg_data[62:0];
				REG_IFACE:   cfg_q.interface_coeff  <= cfg_data[62:0];
				REG_LRANGE:  cfg_q.long_range_coeff <= cfg_data[62:0];
				REG_STAB:    cfg_q.stabilization    <= cfg_data[62:0];
				REG_MEAN:    cfg_q.scaled_mean      <= cfg_data;
				REG_DEALIAS: cfg_q.dealias_on       <= cfg_data[0];
				default: ;
			endcase
		end
	end

	ssimu_front u_front (
		.clk,
		.arst_n,
		.push,
		.full,
		.item,
		.dealias_on(cfg_q.dealias_on),
		.head,
		.head_vld,
		.take
	);

	ssimu_back u_back (
		.clk,
		.arst_n,
		.cfg(cfg_q),
		.head,
		.head_vld,
		.take,
		.result,
		.empty,
		.pop
	);

endmodule

### sim/tb_spectral_semi_implicit_mode_update.sv
// testbench for spectral_semi_implicit_mode_update: directed, configuration, backpressure and random modes
// checked against a built-in fixed-point predictor of the Q32.32 semi-implicit update
// depends on ssimu_pkg and the block's rtl
`timescale 1ns / 100ps

module tb_spectral_semi_implicit_mode_update;
	import ssimu_pkg::*;

	localparam logic [63:0] MASK63 = 64'h7fff_ffff_ffff_ffff;
	localparam int QUIET_LIMIT = 4000;
	localparam int SETTLE = 130;

	logic        clk;
	logic        arst_n;
	logic        push;
	logic        full;
	item_t       item;
	logic        empty;
	logic        pop;
	result_t     result;
	logic        cfg_valid;
	logic        cfg_ready;
	logic [2:0]  cfg_index;
	logic [63:0] cfg_data;

	cfg_t    shadow_cfg;
	result_t mode_results[$];
	logic    sat_seen;
	bit      idle_on;
	int      hold_cycles;
	int      n_items, n_results, n_errors, n_cfg, n_ovf, quiet;

	spectral_semi_implicit_mode_update dut (
		.clk(clk), .arst_n(arst_n), .push(push), .full(full), .item(item),
		.empty(empty), .pop(pop), .result(result), .cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	// clock
	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// apply sign to a magnitude with saturation
	function automatic logic signed [63:0] fx_sign(input logic neg, input logic [63:0] m,
			input logic big);
		if (neg) begin
			if (big || m > 64'h8000_0000_0000_0000) begin
				sat_seen = 1'b1;
				return Q_MIN;
			end
			return -m;
		end
		if (big || m[63]) begin
			sat_seen = 1'b1;
			return Q_MAX;
		end
		return m;
	endfunction

	// q32.32 product, truncated toward zero
	function automatic logic signed [63:0] fx_mul(input logic signed [63:0] a,
			input logic signed [63:0] b);
		logic [63:0]  ma, mb;
		logic [127:0] prod;
		ma = a[63] ? -a : a;
		mb = b[63] ? -b : b;
		prod = {64'd0, ma} * {64'd0, mb};
		return fx_sign(a[63] ^ b[63], prod[95:32], |prod[127:96]);
	endfunction

	// saturating sum, sub selects a - b
	function automatic logic signed [63:0] fx_addsub(input logic signed [63:0] a,
			input logic signed [63:0] b, input bit sub);
		logic signed [64:0] s;
		s = sub ? ($signed({a[63], a}) - $signed({b[63], b}))
			: ($signed({a[63], a}) + $signed({b[63], b}));
		if (s > $signed({1'b0, Q_MAX})) begin
			sat_seen = 1'b1;
			return Q_MAX;
		end
		if (s < $signed({1'b1, Q_MIN})) begin
			sat_seen = 1'b1;
			return Q_MIN;
		end
		return s[63:0];
	endfunction

	// quotient n*2^32/d for positive d
	function automatic logic signed [63:0] fx_div(input logic signed [63:0] n,
			input logic signed [63:0] d);
		logic [63:0]  mn;
		logic [127:0] quo;
		mn = n[63] ? -n : n;
		quo = ({64'd0, mn} << 32) / {64'd0, d};
		return fx_sign(n[63], quo[63:0], |quo[127:64]);
	endfunction

	function automatic logic signed [63:0] sign_rail(input logic signed [63:0] v);
		if (v > 0) return Q_MAX;
		if (v < 0) return Q_MIN;
		return 64'sd0;
	endfunction

	// expected updated coefficient of one mode
	function automatic result_t mode_update(input item_t it);
		logic signed [63:0] dt, k2, k4, cre, cim, dk2, dstab, dek4, ds, den, gain, nre, nim;
		result_t r;
		sat_seen = 1'b0;
		dt = {1'b0, shadow_cfg.step_size};
		k2 = {1'b0, it.sym_k2};
		k4 = {1'b0, it.sym_k4};
		cre = it.cube_re;
		cim = it.cube_im;
		if (shadow_cfg.dealias_on && !it.keep_mode) begin
			cre = 64'sd0;
			cim = 64'sd0;
		end
		dk2 = fx_mul(dt, k2);
		dstab = fx_mul(dt, fx_mul({1'b0, shadow_cfg.stabilization}, k2));
		dek4 = fx_mul(fx_mul(dt, {1'b0, shadow_cfg.interface_coeff}), k4);
		ds = fx_mul(dt, {1'b0, shadow_cfg.long_range_coeff});
		den = fx_addsub(Q_ONE, dk2, 1);
		den = fx_addsub(den, dek4, 0);
		den = fx_addsub(den, ds, 0);
		den = fx_addsub(den, dstab, 0);
		gain = fx_addsub(Q_ONE, dstab, 0);
		nre = fx_addsub(fx_mul(gain, it.lin_re), fx_mul(dk2, cre), 1);
		nim = fx_addsub(fx_mul(gain, it.lin_im), fx_mul(dk2, cim), 1);
		if (it.zero_mode)
			nre = fx_addsub(nre, fx_mul(ds, shadow_cfg.scaled_mean), 0);
		if (den <= 0) begin
			sat_seen = 1'b1;
			nre = sign_rail(nre);
			nim = sign_rail(nim);
		end else begin
			nre = fx_div(nre, den);
			nim = fx_div(nim, den);
		end
		r.new_re = nre;
		r.new_im = nim;
		r.overflow = sat_seen;
		return r;
	endfunction

	// random value: full range, moderate q32.32 magnitude, zero or a rail
	function automatic logic [63:0] pick_value();
		logic [63:0] v;
		v = {$urandom, $urandom};
		case ($urandom_range(9))
			0, 1, 2: ;
			3: v = $urandom_range(1) ? Q_MAX : Q_MIN;
			4: v = 64'd0;
			default: v = {{28{v[63]}}, v[35:0]};
		endcase
		return v;
	endfunction

	function automatic item_t random_mode();
		item_t it;
		logic [63:0] pv;
		it.lin_re = pick_value();
		it.lin_im = pick_value();
		it.cube_re = pick_value();
		it.cube_im = pick_value();
		pv = pick_value();
		it.sym_k2 = $urandom_range(3) == 0 ? pv[62:0]
			: 63'({$urandom_range(64), 32'd0} >> 1);
		pv = pick_value();
		it.sym_k4 = $urandom_range(3) == 0 ? pv[62:0]
			: 63'({$urandom_range(4096), $urandom} >> 2);
		it.keep_mode = 1'($urandom_range(1));
		it.zero_mode = $urandom_range(3) == 0;
		return it;
	endfunction

	// push one mode; push stays high for a following request
	task automatic send_mode(input item_t it);
		if (idle_on && $urandom_range(99) < 10) begin
			push = 1'b0;
			repeat ($urandom_range(1, 6)) @(negedge clk);
		end
		item = it;
		push = 1'b1;
		do @(posedge clk); while (full);
		mode_results.push_back(mode_update(it));
		n_items++;
		@(negedge clk);
	endtask

	// wait until every pending result has arrived, then let the pipeline settle
	task automatic wait_drained();
		push = 1'b0;
		while (mode_results.size() != 0) @(negedge clk);
		repeat (SETTLE) @(negedge clk);
	endtask

	task automatic write_reg(input logic [2:0] idx, input logic [63:0] data);
		cfg_valid = 1'b1;
		cfg_index = idx;
		cfg_data = data;
		do @(posedge clk); while (!cfg_ready);
		case (idx)
			REG_STEP:    shadow_cfg.step_size = data[62:0];
			REG_IFACE:   shadow_cfg.interface_coeff = data[62:0];
			REG_LRANGE:  shadow_cfg.long_range_coeff = data[62:0];
			REG_STAB:    shadow_cfg.stabilization = data[62:0];
			REG_MEAN:    shadow_cfg.scaled_mean = data;
			REG_DEALIAS: shadow_cfg.dealias_on = data[0];
			default: ;
		endcase
		n_cfg++;
		@(negedge clk);
		cfg_valid = 1'b0;
	endtask

	task automatic load_cfg(input logic [63:0] dt, input logic [63:0] eps2,
			input logic [63:0] sigma, input logic [63:0] stab, input logic [63:0] mean,
			input logic dealias);
		write_reg(REG_STEP, dt);
		write_reg(REG_IFACE, eps2);
		write_reg(REG_LRANGE, sigma);
		write_reg(REG_STAB, stab);
		write_reg(REG_MEAN, mean);
		write_reg(REG_DEALIAS, {63'd0, dealias});
	endtask

	// typical physical setting, used by the directed and backpressure tests
	task automatic load_typical(input logic dealias);
		load_cfg(64'h0000_0000_0100_0000, 64'h0000_0000_4000_0000, 64'h0000_0000_2000_0000,
			64'h0000_0002_0000_0000, 64'hffff_fff8_8000_0000, dealias);
	endtask

	// rails of every field, each flag combination, non-positive denominator
	task automatic test_directed();
		item_t it;
		idle_on = 1'b0;
		it = '0;
		send_mode(it);
		it.lin_re = Q_MAX; it.lin_im = Q_MIN; it.cube_re = Q_MIN; it.cube_im = Q_MAX;
		send_mode(it);
		wait_drained();
		load_typical(1'b1);
		for (int f = 0; f < 4; f++) begin
			it.lin_re = 64'sh0000_0003_8000_0000; it.lin_im = -64'sh0000_0001_4000_0000;
			it.cube_re = 64'sh0000_0010_0000_0000; it.cube_im = -64'sh0000_0007_0000_0000;
			it.sym_k2 = 63'h0000_0004_0000_0000; it.sym_k4 = 63'h0000_0010_0000_0000;
			it.keep_mode = f[0]; it.zero_mode = f[1];
			send_mode(it);
		end
		it.sym_k2 = MASK63[62:0]; it.sym_k4 = MASK63[62:0];
		send_mode(it);
		it.sym_k2 = '0; it.sym_k4 = '0;
		it.lin_re = Q_MIN; it.lin_im = Q_MAX; it.cube_re = Q_MAX; it.cube_im = Q_MIN;
		send_mode(it);
		it.lin_re = 64'sd1; it.lin_im = -64'sd1; it.cube_re = 64'sd0; it.cube_im = 64'sd0;
		send_mode(it);
		wait_drained();
		// large dt with no k4 makes the denominator non-positive
		load_cfg(64'h0000_0010_0000_0000, 64'd0, 64'd0, 64'd0, 64'h0000_0001_0000_0000,
			1'b0);
		for (int s = -1; s <= 1; s++) begin
			it = '0;
			it.sym_k2 = 63'h0000_0001_0000_0000;
			it.lin_re = 64'(s); it.lin_im = 64'(-s);
			it.keep_mode = 1'b0;
			send_mode(it);
		end
		wait_drained();
	endtask

	// several settings including the register rails and out-of-range indexes
	task automatic test_settings();
		load_cfg(MASK63, MASK63, MASK63, MASK63, Q_MAX, 1'b1);
		repeat (8) send_mode(random_mode());
		wait_drained();
		load_cfg(64'd0, 64'd0, 64'd0, 64'd0, Q_MIN, 1'b0);
		write_reg(3'd6, {$urandom, $urandom});
		write_reg(3'd7, {$urandom, $urandom});
		repeat (8) send_mode(random_mode());
		wait_drained();
		load_cfg({$urandom, $urandom}, {$urandom, $urandom}, {$urandom, $urandom},
			{$urandom, $urandom}, {$urandom, $urandom}, 1'b1);
		repeat (8) send_mode(random_mode());
		wait_drained();
	endtask

	// receiver holds off while modes keep coming, then a full stop of the sender
	task automatic test_backpressure();
		load_typical(1'b0);
		idle_on = 1'b1;
		hold_cycles = 400;
		repeat (60) send_mode(random_mode());
		wait_drained();
		repeat (20) send_mode(random_mode());
		wait_drained();
	endtask

	// random modes over a series of random moderate settings
	task automatic test_random();
		for (int phase = 0; phase < 6; phase++) begin
			load_cfg(64'({$urandom_range(255), 24'd0}), {$urandom_range(3), $urandom},
				{$urandom_range(1), $urandom}, {$urandom_range(15), $urandom},
				{{24{1'b0}}, $urandom, 8'd0} - 64'h0000_0080_0000_0000,
				1'($urandom_range(1)));
			idle_on = (phase != 2);
			repeat (130) send_mode(random_mode());
			wait_drained();
		end
	endtask

	// result side: random pop, long hold-off on request
	initial begin
		pop = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_cycles > 0) begin
				hold_cycles--;
				pop = 1'b0;
			end else begin
				pop = idle_on ? ($urandom_range(99) >= 10) : 1'b1;
			end
		end
	end

	// compare each popped result with the oldest expectation
	always @(posedge clk) begin
		if (arst_n && pop && !empty) begin
			n_results++;
			if (mode_results.size() == 0) begin
				$display("%0t: unexpected result re=%h im=%h ovf=%b", $time,
					result.new_re, result.new_im, result.overflow);
				n_errors++;
			end else begin
				result_t want;
				want = mode_results.pop_front();
				if (want.overflow) n_ovf++;
				if (result.new_re !== want.new_re) begin
					$display("%0t: new_re expected %h got %h", $time, want.new_re,
						result.new_re);
					n_errors++;
				end
				if (result.new_im !== want.new_im) begin
					$display("%0t: new_im expected %h got %h", $time, want.new_im,
						result.new_im);
					n_errors++;
				end
				if (result.overflow !== want.overflow) begin
					$display("%0t: overflow expected %b got %b", $time, want.overflow,
						result.overflow);
					n_errors++;
				end
			end
		end
	end

	// watchdog on cycles with no accepted request
	always @(posedge clk) begin
		if ((push && !full) || (pop && !empty) || (cfg_valid && cfg_ready))
			quiet = 0;
		else
			quiet++;
		if (quiet >= QUIET_LIMIT) begin
			$display("%0t: no progress for %0d cycles", $time, QUIET_LIMIT);
			$display("Some tests failed");
			$finish;
		end
	end

	initial begin
		arst_n = 1'b0;
		push = 1'b0;
		item = '0;
		cfg_valid = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		shadow_cfg = '0;
		idle_on = 1'b0;
		hold_cycles = 0;
		n_items = 0; n_results = 0; n_errors = 0; n_cfg = 0; n_ovf = 0; quiet = 0;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);
		test_directed();
		test_settings();
		test_backpressure();
		test_random();
		wait_drained();
		$display("covered %0d modes, %0d results (%0d saturated), %0d register writes",
			n_items, n_results, n_ovf, n_cfg);
		$display("settings from zero to the register rails, dealias on and off, stalls");
		if (n_errors == 0 && mode_results.size() == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule
